@@ hw/rtl/ssfg_pkg.sv @@
// ssfg_pkg: shared types and constants for the fixed-gap Shell sorter.
// No dependencies; the interfaces and the top level import it.
`default_nettype none

package ssfg_pkg;

  localparam int VALUE_W  = 32;
  localparam int NUM_GAPS = 5;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [3:0]                gap_t;
  typedef logic [2:0]                gap_idx_t;

  // Gap sequence, largest first; the final pass is a plain insertion sort.
  localparam gap_t GAP_TABLE [NUM_GAPS] = '{4'd9, 4'd5, 4'd3, 4'd2, 4'd1};
  localparam gap_idx_t LAST_GAP = gap_idx_t'(NUM_GAPS - 1);

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_PASS,
    ST_FETCH,
    ST_LATCH,
    ST_PROBE,
    ST_CMP,
    ST_NEXT,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/ssfg_if.sv @@
// ssfg_if: valid/ready stream interfaces for the sorter's input and result channels.
// Depends on ssfg_pkg for the value type.
`default_nettype none

interface ssfg_in_if import ssfg_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t value;
  logic   last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink   (input valid, input value, input last_item, output ready);
endinterface

interface ssfg_out_if import ssfg_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t sorted_value;
  logic   last_result;
  logic   overflow;

  modport source (output valid, output sorted_value, output last_result,
                  output overflow, input ready);
  modport sink   (input valid, input sorted_value, input last_result,
                  input overflow, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ssfg_ram.sv @@
// ssfg_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ssfg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/shell_sort_fixed_gaps_top.sv @@
// shell_sort_fixed_gaps_top: collects a set of signed values, sorts them by Shell
// sort with gaps 9, 5, 3, 2, 1 and streams them out. Uses ssfg_pkg, ssfg_if, ssfg_ram.
//
// Usage:
//   items   : valid/ready input; one beat carries value and last_item. Beats are
//             taken one per cycle while the block collects a set. The beat with
//             last_item set closes the set. Up to CAPACITY values are kept; any
//             further beat (the closing one too) is dropped and flags overflow.
//   results : valid/ready output; one beat per kept value, ascending, with
//             last_result on the final one and overflow on every beat of a set
//             that lost values.
// Sequencing:
//   Sorting runs on one comparator and one RAM read port: each gap pass has a
//   pass step, each element visited is fetched, latched, probed, compared and
//   followed by a next step, and each position it moves down adds a compare and
//   a probe; the final compare is skipped when it comes to rest at the bottom of
//   its gap chain. Each result beat is read, loaded, then held until taken.
//   items.ready is low from the closing beat until the last result beat is taken.
// Reset: rst returns to collecting an empty set; the RAM is not cleared, only
//   entries written for the current set are read.
// Stall: a result beat holds on the port until results.ready; nothing advances.
`default_nettype none

module shell_sort_fixed_gaps_top
  import ssfg_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input wire logic   clk,
  input wire logic   rst,
  ssfg_in_if.sink    items,
  ssfg_out_if.source results
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IW    = (CNT_W > 4) ? CNT_W : 4;

  state_t state, state_next;

  logic [CNT_W-1:0] count;
  logic             dropped;
  gap_idx_t         g;
  logic [IW-1:0]    i;
  logic [IW-1:0]    j;
  logic [CNT_W-1:0] k;
  value_t           x;
  value_t           out_value;
  logic             out_last;
  logic             out_ovf;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;

  logic [IW-1:0] gap;
  logic [IW-1:0] cnt_w;
  logic [IW-1:0] i_inc;
  logic [IW-1:0] j_back;
  logic          j_ge_gap;
  logic          x_lt_y;
  logic          has_room;
  logic          in_beat;
  logic          out_beat;

  ssfg_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign gap      = IW'(GAP_TABLE[g]);
  assign cnt_w    = IW'(count);
  assign i_inc    = i + IW'(1);
  assign j_back   = j - gap;
  assign j_ge_gap = (j >= gap);
  assign x_lt_y   = (x < $signed(ram_rdata));
  assign has_room = (count < CNT_W'(CAPACITY));
  assign in_beat  = items.valid && items.ready;
  assign out_beat = results.valid && results.ready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (in_beat && items.last_item) state_next = ST_PASS;
      end
      ST_PASS: begin
        if (gap < cnt_w)          state_next = ST_FETCH;
        else if (g == LAST_GAP)   state_next = ST_EMIT_RD;
      end
      ST_FETCH: state_next = ST_LATCH;
      ST_LATCH: state_next = ST_PROBE;
      ST_PROBE: begin
        state_next = j_ge_gap ? ST_CMP : ST_NEXT;
      end
      ST_CMP: begin
        state_next = x_lt_y ? ST_PROBE : ST_NEXT;
      end
      ST_NEXT: begin
        if (i_inc < cnt_w)        state_next = ST_FETCH;
        else if (g == LAST_GAP)   state_next = ST_EMIT_RD;
        else                      state_next = ST_PASS;
      end
      ST_EMIT_RD: state_next = ST_EMIT_LD;
      ST_EMIT_LD: state_next = ST_EMIT_WAIT;
      ST_EMIT_WAIT: begin
        if (results.ready) state_next = out_last ? ST_LOAD : ST_EMIT_RD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // Outputs and RAM control
  always_comb begin
    items.ready   = 1'b0;
    results.valid = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = x;
    ram_raddr     = '0;
    case (state)
      ST_LOAD: begin
        items.ready = 1'b1;
        ram_we      = items.valid && has_room;
        ram_waddr   = count[AW-1:0];
        ram_wdata   = items.value;
      end
      ST_FETCH: begin
        ram_raddr = i[AW-1:0];
      end
      ST_PROBE: begin
        ram_raddr = j_back[AW-1:0];
        ram_we    = !j_ge_gap;
        ram_waddr = j[AW-1:0];
      end
      ST_CMP: begin
        // shift the larger neighbor up, or drop x into its slot
        ram_we    = 1'b1;
        ram_waddr = j[AW-1:0];
        ram_wdata = x_lt_y ? ram_rdata : x;
      end
      ST_EMIT_RD: begin
        ram_raddr = k[AW-1:0];
      end
      ST_EMIT_WAIT: begin
        results.valid = 1'b1;
      end
      default: ;
    endcase
  end

  assign results.sorted_value = out_value;
  assign results.last_result  = out_last;
  assign results.overflow     = out_ovf;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      count   <= '0;
      dropped <= 1'b0;
      g       <= '0;
      i       <= '0;
      j       <= '0;
      k       <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_LOAD: begin
          if (in_beat) begin
            if (has_room) count   <= count + CNT_W'(1);
            else          dropped <= 1'b1;
            g <= '0;
            k <= '0;
          end
        end
        ST_PASS: begin
          i <= gap;
          if (!(gap < cnt_w)) g <= g + gap_idx_t'(1);
        end
        ST_LATCH: j <= i;
        ST_CMP: begin
          if (x_lt_y) j <= j_back;
        end
        ST_NEXT: begin
          i <= i_inc;
          if (!(i_inc < cnt_w)) g <= g + gap_idx_t'(1);
        end
        ST_EMIT_WAIT: begin
          if (results.ready) begin
            k <= k + CNT_W'(1);
            if (out_last) begin
              count   <= '0;
              dropped <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == ST_LATCH) begin
      x <= $signed(ram_rdata);
    end
    if (state == ST_EMIT_LD) begin
      out_value <= $signed(ram_rdata);
      out_last  <= (k + CNT_W'(1) == count);
      out_ovf   <= dropped;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("element count beyond capacity");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(items.ready && results.valid))
    else $error("collecting and emitting at once");

  a_write_in_set: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (CNT_W'(ram_waddr) <= count))
    else $error("store write outside the current set");

  a_clear_after_set: assert property (@(posedge clk) disable iff (rst)
    (out_beat && results.last_result) |=> (count == '0 && !dropped))
    else $error("set state not cleared after final result");

endmodule

`default_nettype wire

@@ dv/shell_sort_fixed_gaps_top_test.sv @@
// Testbench for shell_sort_fixed_gaps_top: sets of signed values go in, each set
// is predicted by a plain sort and the result beats are checked in order.
// Depends on ssfg_pkg, ssfg_in_if, ssfg_out_if and the top level.

module shell_sort_fixed_gaps_top_test
  import ssfg_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY     = 64;
  localparam int RANDOM_ITEMS = 350;
  localparam int STALL_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    value_t value;
    logic   is_last;
  } set_item_t;

  typedef struct {
    value_t value;
    logic   is_last;
    logic   overflow;
  } sorted_beat_t;

  typedef enum {FILL_WIDE, FILL_NARROW, FILL_EDGES, FILL_MIXED} fill_t;

  localparam value_t EDGE_VALUES [7] = '{
    32'sh8000_0000, 32'sh8000_0001, -32'sd1, 32'sd0, 32'sd1,
    32'sh7fff_fffe, 32'sh7fff_ffff
  };

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  value_t in_value = '0;
  logic   in_last = 1'b0;
  logic   out_ready = 1'b0;

  logic   in_beat = 1'b0;
  logic   out_beat = 1'b0;
  bit     in_calm = 1'b0;
  bit     out_calm = 1'b0;
  int     in_wait = 0;
  int     out_wait = 0;
  int     idle_cycles = 0;
  int     error_count = 0;

  set_item_t    pending_items [$];
  sorted_beat_t sorted_beats_due [$];

  // Predictor state: the set being collected.
  value_t held_values [CAPACITY];
  int     held_count = 0;
  bit     set_lost = 1'b0;

  ssfg_in_if  items ();
  ssfg_out_if results ();

  assign items.valid     = in_valid;
  assign items.value     = in_value;
  assign items.last_item = in_last;
  assign results.ready   = out_ready;

  shell_sort_fixed_gaps_top #(.CAPACITY(CAPACITY)) u_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items),
    .results (results)
  );

  initial forever #2 clk = ~clk;

  function automatic int draw_wait(bit calm);
    return calm ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic value_t draw_value(fill_t fill);
    fill_t pick;
    pick = fill;
    if (pick == FILL_MIXED) pick = fill_t'($urandom_range(0, 2));
    case (pick)
      FILL_NARROW: return value_t'(int'($urandom_range(0, 6)) - 3);
      FILL_EDGES:  return EDGE_VALUES[$urandom_range(0, 6)];
      default:     return value_t'($urandom);
    endcase
  endfunction

  task automatic push_item(value_t v, logic is_last);
    set_item_t it;
    it.value   = v;
    it.is_last = is_last;
    pending_items.push_back(it);
  endtask

  task automatic queue_set(int count, fill_t fill);
    for (int k = 0; k < count; k++) push_item(draw_value(fill), k == count - 1);
  endtask

  // Hold the element if room remains; on the closing beat sort and post the set.
  task automatic collect_element(value_t v, logic is_last);
    int i, j;
    value_t key;
    sorted_beat_t b;
    if (held_count < CAPACITY) begin
      held_values[held_count] = v;
      held_count++;
    end else begin
      set_lost = 1'b1;
    end
    if (is_last) begin
      for (i = 1; i < held_count; i++) begin
        key = held_values[i];
        j = i;
        while (j > 0 && held_values[j-1] > key) begin
          held_values[j] = held_values[j-1];
          j--;
        end
        held_values[j] = key;
      end
      for (i = 0; i < held_count; i++) begin
        b.value    = held_values[i];
        b.is_last  = (i == held_count - 1);
        b.overflow = set_lost;
        sorted_beats_due.push_back(b);
      end
      held_count = 0;
      set_lost   = 1'b0;
    end
  endtask

  // Item driver: hold a beat until taken, then idle for the drawn gap.
  always @(negedge clk) begin : drive_items
    set_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      in_wait  <= draw_wait(in_calm);
    end else if (!in_valid || in_beat) begin
      if (in_wait > 0) begin
        in_valid <= 1'b0;
        in_wait  <= in_wait - 1;
      end else if (pending_items.size() != 0) begin
        nxt = pending_items.pop_front();
        in_valid <= 1'b1;
        in_value <= nxt.value;
        in_last  <= nxt.is_last;
        in_wait  <= draw_wait(in_calm);
        if ($urandom_range(0, 39) == 0) in_calm <= !in_calm;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: stall each beat for a drawn number of cycles.
  always @(negedge clk) begin : drive_ready
    int w;
    if (rst) begin
      out_ready <= 1'b0;
      out_wait  <= 0;
    end else if (out_beat) begin
      w = draw_wait(out_calm);
      out_ready <= (w == 0);
      out_wait  <= w;
      if ($urandom_range(0, 39) == 0) out_calm <= !out_calm;
    end else if (out_wait > 0) begin
      out_ready <= (out_wait == 1);
      out_wait  <= out_wait - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : monitor
    sorted_beat_t exp_beat;
    logic got_in, got_out;
    got_in  = !rst && in_valid && items.ready;
    got_out = !rst && results.valid && out_ready;
    in_beat  <= got_in;
    out_beat <= got_out;
    if (got_in) collect_element(in_value, in_last);
    if (got_out) begin
      if (sorted_beats_due.size() == 0) begin
        $display("%0t: unexpected result beat: value %0d last %0b overflow %0b",
                 $time, results.sorted_value, results.last_result, results.overflow);
        error_count++;
      end else begin
        exp_beat = sorted_beats_due.pop_front();
        if (results.sorted_value !== exp_beat.value ||
            results.last_result !== exp_beat.is_last ||
            results.overflow !== exp_beat.overflow) begin
          $display("%0t: mismatch: expected value %0d last %0b overflow %0b, got value %0d last %0b overflow %0b",
                   $time, exp_beat.value, exp_beat.is_last, exp_beat.overflow,
                   results.sorted_value, results.last_result, results.overflow);
          error_count++;
        end
      end
    end
    idle_cycles <= (got_in || got_out) ? 0 : idle_cycles + 1;
  end

  initial begin : watchdog
    wait (idle_cycles >= STALL_LIMIT);
    $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int set_no, n, random_total;
    fill_t fill;

    // Single-element sets at both ends of the range.
    push_item(32'sh8000_0000, 1'b1);
    push_item(32'sh7fff_ffff, 1'b1);
    // Extremes with duplicates.
    push_item(32'sh7fff_ffff, 1'b0);
    push_item(32'sh8000_0000, 1'b0);
    push_item(32'sd0, 1'b0);
    push_item(-32'sd1, 1'b0);
    push_item(32'sd1, 1'b0);
    push_item(32'sh8000_0000, 1'b0);
    push_item(32'sh7fff_ffff, 1'b1);
    // Descending run long enough for the widest gap to move elements.
    for (int k = 0; k < 12; k++) push_item(value_t'(1000 - 150 * k), k == 11);

    set_no = 0;
    random_total = 0;
    while (random_total < RANDOM_ITEMS) begin
      if (set_no == 2) begin
        n = CAPACITY;
      end else if (set_no == 5) begin
        n = $urandom_range(CAPACITY + 1, CAPACITY + 6);
      end else begin
        case ($urandom_range(0, 19))
          0:       n = CAPACITY;
          1:       n = $urandom_range(CAPACITY + 1, CAPACITY + 6);
          2, 3:    n = $urandom_range(17, CAPACITY - 1);
          default: n = $urandom_range(1, 16);
        endcase
      end
      fill = fill_t'($urandom_range(0, 3));
      queue_set(n, fill);
      random_total += n;
      set_no++;
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || in_valid || held_count != 0 ||
           sorted_beats_due.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && sorted_beats_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
